[src/imup_pkg.sv]
`default_nettype none

package imup_pkg;

  localparam int PAYLOAD_MAX = 32;
  localparam int PIDX_W = $clog2(PAYLOAD_MAX + 1);
  localparam int ADDR_W = $clog2(PAYLOAD_MAX);

  localparam logic [7:0] SYNC_MARK = 8'h55;
  localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_MAX);

  localparam logic [7:0] KIND_ATT  = 8'd1;
  localparam logic [7:0] KIND_IMU  = 8'd3;
  localparam logic [7:0] KIND_TEMP = 8'd4;

  localparam logic [PIDX_W-1:0] LEN_ATT  = PIDX_W'(6);
  localparam logic [PIDX_W-1:0] LEN_IMU  = PIDX_W'(12);
  localparam logic [PIDX_W-1:0] LEN_TEMP = PIDX_W'(8);

  localparam logic [2:0] CH_ATT_LAST   = 3'd2;
  localparam logic [2:0] CH_IMU_LAST   = 3'd5;
  localparam logic [2:0] CH_GYRO_FIRST = 3'd3;
  localparam logic [2:0] CH_TEMP       = 3'd3;

  localparam logic [14:0] ATT_SCALE    = 15'd180;
  localparam logic [14:0] UNITY_SCALE  = 15'd1;
  localparam logic [14:0] ACCEL_FS_RST = 15'd4;
  localparam logic [14:0] GYRO_FS_RST  = 15'd2000;

  localparam logic CFG_ACCEL = 1'b0;
  localparam logic CFG_GYRO  = 1'b1;

  typedef enum logic [1:0] {
    ST_VALUE,
    ST_NOVAL,
    ST_BADSUM,
    ST_BADLEN
  } res_status_t;

  typedef enum logic [2:0] {
    UNIT_DEG,
    UNIT_G,
    UNIT_DPS,
    UNIT_CDEG,
    UNIT_NONE
  } unit_t;

  typedef enum logic [1:0] {
    FR_ATT,
    FR_IMU,
    FR_TEMP,
    FR_OTHER
  } frame_class_t;

  typedef struct packed {
    logic        sync_a;
    logic        add_sum;
    logic        load_kind;
    logic        load_len;
    logic        store_data;
    logic        count_good;
    logic        count_bad;
    logic        emit_begin;
    res_status_t emit_status;
    logic        rd;
    logic        mul;
    logic        out_load;
    logic        chan_step;
  } imup_cmd_t;

  typedef struct packed {
    logic         sync_hit;
    logic         len_bad;
    logic         len_zero;
    logic         data_done;
    logic         sum_ok;
    frame_class_t fclass;
    logic         emit_last;
    logic         out_free;
  } imup_stat_t;

endpackage

`default_nettype wire

[src/imu_frame_parser_core.sv]
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   rx_byte
// out      output     out_valid / out_ready status, frame_kind, channel, raw_value,
//                                           scaled_value, unit, last, good_count, bad_count
// cfg      input      cfg_we (no wait)      cfg_index, cfg_data
//
// one byte per cycle is taken while a frame is being collected, also while a result
// still sits in the output register
// the checksum byte of an attitude, imu or temperature frame starts, for each value in turn:
// a two-port read of the payload store, one 16x16 multiply, then the result load
// other results (bad checksum, bad length, no value) go straight to the result load
// reset (rst, synchronous) returns the parser to the first sync search, clears both
// totals and restores the full scale registers; the payload store is not cleared
// a stalled out_ready holds the result sequencer, and no byte is taken meanwhile
`default_nettype none

module imu_frame_parser_core import imup_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  // byte stream
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         rx_byte,
  // results
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic [7:0]         frame_kind,
  output logic [2:0]         channel,
  output logic signed [15:0] raw_value,
  output logic signed [30:0] scaled_value,
  output logic [2:0]         unit,
  output logic               last,
  output logic [31:0]        good_count,
  output logic [31:0]        bad_count,
  // configuration writes
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [14:0]        cfg_data
);

  imup_cmd_t  cmd;
  imup_stat_t stat;

  // parse phase and result sequencing
  imup_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // header, checksum, payload store, multiplier and result register
  imup_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .frame_kind   (frame_kind),
    .channel      (channel),
    .raw_value    (raw_value),
    .scaled_value (scaled_value),
    .unit         (unit),
    .last         (last),
    .good_count   (good_count),
    .bad_count    (bad_count)
  );

`ifndef SYNTH
  // results are only produced while no byte can be taken
  a_load_not_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !in_ready)
    else $error("result loaded while taking bytes");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // a frame is counted once, as good or as bad
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    cmd.count_good |-> !cmd.count_bad)
    else $error("frame counted twice");

  // value results always carry a unit
  a_value_unit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_VALUE) |-> (unit != UNIT_NONE))
    else $error("value result without unit");
`endif

endmodule

`default_nettype wire

[src/imup_ctrl.sv]
`default_nettype none

module imup_ctrl import imup_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  imup_stat_t stat,
  output imup_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_SYNC_A,
    S_SYNC_B,
    S_KIND,
    S_LEN,
    S_DATA,
    S_CHECK,
    E_READ,
    E_MUL,
    E_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    in_ready = (state == S_SYNC_A) || (state == S_SYNC_B) || (state == S_KIND) ||
               (state == S_LEN) || (state == S_DATA) || (state == S_CHECK);
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.emit_status = ST_NOVAL;
    state_next = state;
    unique case (state)
      S_SYNC_A: begin
        if (accept && stat.sync_hit) begin
          cmd.sync_a = 1'b1;
          state_next = S_SYNC_B;
        end
      end
      S_SYNC_B: begin
        if (accept) begin
          if (stat.sync_hit) begin
            cmd.add_sum = 1'b1;
            state_next = S_KIND;
          end else begin
            state_next = S_SYNC_A;
          end
        end
      end
      S_KIND: begin
        if (accept) begin
          cmd.load_kind = 1'b1;
          cmd.add_sum = 1'b1;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          if (stat.len_bad) begin
            cmd.count_bad = 1'b1;
            cmd.emit_begin = 1'b1;
            cmd.emit_status = ST_BADLEN;
            state_next = E_OUT;
          end else begin
            cmd.load_len = 1'b1;
            state_next = stat.len_zero ? S_CHECK : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.store_data = 1'b1;
          if (stat.data_done) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (accept) begin
          cmd.emit_begin = 1'b1;
          if (!stat.sum_ok) begin
            cmd.count_bad = 1'b1;
            cmd.emit_status = ST_BADSUM;
            state_next = E_OUT;
          end else if (stat.fclass == FR_OTHER) begin
            cmd.count_good = 1'b1;
            cmd.emit_status = ST_NOVAL;
            state_next = E_OUT;
          end else begin
            cmd.count_good = 1'b1;
            cmd.emit_status = ST_VALUE;
            state_next = E_READ;
          end
        end
      end
      E_READ: begin
        cmd.rd = 1'b1;
        state_next = E_MUL;
      end
      E_MUL: begin
        cmd.mul = 1'b1;
        state_next = E_OUT;
      end
      E_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_last) begin
            state_next = S_SYNC_A;
          end else begin
            cmd.chan_step = 1'b1;
            state_next = E_READ;
          end
        end
      end
      default: begin
        state_next = S_SYNC_A;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SYNC_A;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/imup_dp.sv]
`default_nettype none

module imup_dp import imup_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire  [7:0]         rx_byte,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [14:0]        cfg_data,
  input  imup_cmd_t          cmd,
  output imup_stat_t         stat,
  input  wire                out_ready,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic [7:0]         frame_kind,
  output logic [2:0]         channel,
  output logic signed [15:0] raw_value,
  output logic signed [30:0] scaled_value,
  output logic [2:0]         unit,
  output logic               last,
  output logic [31:0]        good_count,
  output logic [31:0]        bad_count
);

  logic [14:0]       accel_fs;
  logic [14:0]       gyro_fs;
  logic [7:0]        held_kind;
  logic [PIDX_W-1:0] held_length;
  logic [PIDX_W-1:0] payload_index;
  logic [7:0]        running_sum;
  logic [31:0]       good_total;
  logic [31:0]       bad_total;
  logic [7:0]        mem [PAYLOAD_MAX];
  logic [7:0]        rd_lo;
  logic [7:0]        rd_hi;
  logic [2:0]        chan;
  res_status_t       mode;
  logic signed [30:0] prod;

  frame_class_t       fclass;
  logic               is_value;
  logic               class_last;
  logic [14:0]        factor;
  unit_t              unit_sel;
  logic signed [15:0] raw;
  logic signed [31:0] prod_full;
  logic [PIDX_W:0]    index_inc;
  logic [ADDR_W-1:0]  addr_lo;
  logic [ADDR_W-1:0]  addr_hi;

  // frame decode from the held header
  always_comb begin
    if (held_kind == KIND_ATT && held_length == LEN_ATT) begin
      fclass = FR_ATT;
    end else if (held_kind == KIND_IMU && held_length == LEN_IMU) begin
      fclass = FR_IMU;
    end else if (held_kind == KIND_TEMP && held_length == LEN_TEMP) begin
      fclass = FR_TEMP;
    end else begin
      fclass = FR_OTHER;
    end
  end

  assign is_value  = (mode == ST_VALUE);
  assign index_inc = {1'b0, payload_index} + (PIDX_W + 1)'(1);
  assign addr_lo   = ADDR_W'({chan, 1'b0});
  assign addr_hi   = ADDR_W'({chan, 1'b1});
  assign raw       = $signed({rd_hi, rd_lo});

  always_comb begin
    unique case (fclass)
      FR_ATT:   class_last = (chan == CH_ATT_LAST);
      FR_IMU:   class_last = (chan == CH_IMU_LAST);
      FR_TEMP:  class_last = 1'b1;
      FR_OTHER: class_last = 1'b1;
      default:  class_last = 1'b1;
    endcase
  end

  always_comb begin
    unique case (fclass)
      FR_ATT: begin
        factor = ATT_SCALE;
        unit_sel = UNIT_DEG;
      end
      FR_IMU: begin
        factor = (chan < CH_GYRO_FIRST) ? accel_fs : gyro_fs;
        unit_sel = (chan < CH_GYRO_FIRST) ? UNIT_G : UNIT_DPS;
      end
      FR_TEMP: begin
        factor = UNITY_SCALE;
        unit_sel = UNIT_CDEG;
      end
      default: begin
        factor = UNITY_SCALE;
        unit_sel = UNIT_NONE;
      end
    endcase
  end

  assign prod_full = raw * $signed({1'b0, factor});

  always_comb begin
    stat.sync_hit  = (rx_byte == SYNC_MARK);
    stat.len_bad   = (rx_byte > LEN_LIMIT);
    stat.len_zero  = (rx_byte == 8'd0);
    stat.data_done = (index_inc >= {1'b0, held_length});
    stat.sum_ok    = (rx_byte == running_sum);
    stat.fclass    = fclass;
    stat.emit_last = !is_value || class_last;
    stat.out_free  = !out_valid || out_ready;
  end

  // configuration, a zero write keeps the old value
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_fs <= ACCEL_FS_RST;
      gyro_fs <= GYRO_FS_RST;
    end else if (cfg_we && cfg_data != 15'd0) begin
      unique case (cfg_index)
        CFG_ACCEL: accel_fs <= cfg_data;
        CFG_GYRO:  gyro_fs <= cfg_data;
        default:   accel_fs <= accel_fs;
      endcase
    end
  end

  // header, checksum and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      held_kind <= '0;
      held_length <= '0;
      payload_index <= '0;
      running_sum <= '0;
      good_total <= '0;
      bad_total <= '0;
      chan <= '0;
      mode <= ST_NOVAL;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sync_a) begin
        running_sum <= rx_byte;
      end
      if (cmd.add_sum || cmd.load_len || cmd.store_data) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.load_kind) begin
        held_kind <= rx_byte;
      end
      if (cmd.load_len) begin
        held_length <= rx_byte[PIDX_W-1:0];
        payload_index <= '0;
      end
      if (cmd.store_data) begin
        payload_index <= index_inc[PIDX_W-1:0];
      end
      if (cmd.count_good) begin
        good_total <= good_total + 32'd1;
      end
      if (cmd.count_bad) begin
        bad_total <= bad_total + 32'd1;
      end
      if (cmd.emit_begin) begin
        mode <= cmd.emit_status;
        chan <= (cmd.emit_status == ST_VALUE && fclass == FR_TEMP) ? CH_TEMP : 3'd0;
      end else if (cmd.chan_step) begin
        chan <= chan + 3'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload store, two registered read ports for one word
  always_ff @(posedge clk) begin
    if (cmd.store_data && payload_index < PIDX_W'(PAYLOAD_MAX)) begin
      mem[payload_index[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd) begin
      rd_lo <= mem[addr_lo];
      rd_hi <= mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= prod_full[30:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= mode;
      frame_kind <= held_kind;
      channel <= is_value ? chan : 3'd0;
      raw_value <= is_value ? raw : 16'sd0;
      scaled_value <= is_value ? prod : 31'sd0;
      unit <= is_value ? unit_sel : UNIT_NONE;
      last <= stat.emit_last;
      good_count <= good_total;
      bad_count <= bad_total;
    end
  end

endmodule

`default_nettype wire
